/* src/met_pkg.sv */
// Shared types and constants for the multi-slot event timer table.
`timescale 1ns / 1ps
`default_nettype none
package met_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);

    localparam int CMD_W   = 3;
    localparam int TASK_W  = 4;
    localparam int EVENT_W = 16;
    localparam int COUNT_W = 32;

    localparam logic [CMD_W-1:0] CMD_START_ONE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START_PER = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd5;

    localparam logic KIND_REPLY   = 1'b0;
    localparam logic KIND_FIRED   = 1'b1;
    localparam logic OUTCOME_OK   = 1'b0;
    localparam logic OUTCOME_FAIL = 1'b1;

    typedef enum logic [2:0] {
        OP_START_ONE,
        OP_START_PER,
        OP_RESTART,
        OP_STOP,
        OP_QUERY,
        OP_TICK,
        OP_BAD
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [TASK_W-1:0]  task_id;
        logic [EVENT_W-1:0] event_num;
        logic [COUNT_W-1:0] timeout;
    } cmd_t;

    typedef struct packed {
        logic               periodic;
        logic [TASK_W-1:0]  task_id;
        logic [EVENT_W-1:0] event_num;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] limit;
    } slot_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FLUSH
    } bk_state_t;

endpackage
`default_nettype wire

/* src/met_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module met_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* src/met_front.sv */
// Front end: accepts input items, decodes the command and queues them for the engine.
`timescale 1ns / 1ps
`default_nettype none
module met_front import met_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [CMD_W-1:0]   s_command,
    input  wire logic [TASK_W-1:0]  s_task_id,
    input  wire logic [EVENT_W-1:0] s_event_id,
    input  wire logic [COUNT_W-1:0] s_timeout,
    output cmd_t                    cmd,
    output logic                    cmd_valid,
    input  wire logic               cmd_ready
);

    localparam int DEPTH = 2;

    cmd_t       q_reg [DEPTH];
    cmd_t       in_cmd;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       push, pop;

    always_comb begin
        in_cmd.task_id   = s_task_id;
        in_cmd.event_num = s_event_id;
        in_cmd.timeout   = s_timeout;
        case (s_command)
            CMD_START_ONE: in_cmd.op = OP_START_ONE;
            CMD_START_PER: in_cmd.op = OP_START_PER;
            CMD_RESTART:   in_cmd.op = OP_RESTART;
            CMD_STOP:      in_cmd.op = OP_STOP;
            CMD_QUERY:     in_cmd.op = OP_QUERY;
            CMD_TICK:      in_cmd.op = OP_TICK;
            default:       in_cmd.op = OP_BAD;
        endcase
    end

    assign s_ready   = (fill_reg != 2'(DEPTH));
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule
`default_nettype wire

/* src/met_back.sv */
// Back end: sweeps the slot table one slot per cycle unless stalled; drives the result register.
`timescale 1ns / 1ps
`default_nettype none
module met_back import met_pkg::*; #(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cmd_t               cmd,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_kind,
    output logic                    m_outcome,
    output logic [TASK_W-1:0]       m_fired_task,
    output logic [EVENT_W-1:0]      m_fired_event,
    output logic                    m_last
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int SLOT_W = $bits(slot_t);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

    bk_state_t state_reg, state_next;
    cmd_t      cur_reg, cur_next;

    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]     p_idx_reg, p_idx_next;
    logic                 p_valid_reg, p_valid_next;
    logic [SLOTS-1:0]     active_reg, active_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [TASK_W-1:0]    pend_task_reg, pend_task_next;
    logic [EVENT_W-1:0]   pend_event_reg, pend_event_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 m_kind_reg, m_kind_next;
    logic                 m_outcome_reg, m_outcome_next;
    logic [TASK_W-1:0]    m_task_reg, m_task_next;
    logic [EVENT_W-1:0]   m_event_reg, m_event_next;
    logic                 m_last_reg, m_last_next;

    logic                 ram_we, ram_re;
    slot_t                ram_wdata;
    logic [SLOT_W-1:0]    ram_rdata;
    slot_t                entry;

    logic out_free, issuing, is_act, match, at_end, fire, cap, hit, stall, finish;

    met_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (p_idx_reg),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (ram_rdata)
    );

    assign entry    = slot_t'(ram_rdata);
    assign out_free = !m_valid_reg || m_ready;
    assign issuing  = (rd_idx_reg < SLOTS_CNT);
    assign is_act   = active_reg[p_idx_reg];
    assign match    = is_act && (entry.task_id == cur_reg.task_id)
                      && (entry.event_num == cur_reg.event_num);
    assign at_end   = (p_idx_reg == LAST_IDX);
    assign fire     = is_act && (entry.count > entry.limit);
    assign cap      = fire && (res_cnt_reg < RES_CNT_W'(MAX_RESULTS));

    always_comb begin
        case (cur_reg.op)
            OP_START_ONE, OP_START_PER: hit = !is_act;
            OP_RESTART, OP_STOP, OP_QUERY: hit = match;
            default: hit = 1'b0;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        rd_idx_next     = rd_idx_reg;
        p_idx_next      = p_idx_reg;
        p_valid_next    = p_valid_reg;
        active_next     = active_reg;
        res_cnt_next    = res_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_task_next  = pend_task_reg;
        pend_event_next = pend_event_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_kind_next     = m_kind_reg;
        m_outcome_next  = m_outcome_reg;
        m_task_next     = m_task_reg;
        m_event_next    = m_event_reg;
        m_last_next     = m_last_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_wdata       = entry;
        cmd_ready       = 1'b0;
        stall           = 1'b0;
        finish          = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cur_next        = cmd;
                    rd_idx_next     = '0;
                    p_valid_next    = 1'b0;
                    res_cnt_next    = '0;
                    pend_valid_next = 1'b0;
                    state_next      = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (p_valid_reg) begin
                    if (cur_reg.op == OP_TICK) begin
                        // A new firing pushes out the one held back, so last can be set at the end.
                        stall = cap && pend_valid_reg && !out_free;
                        if (!stall) begin
                            if (is_act) begin
                                ram_we          = 1'b1;
                                ram_wdata.count = (fire && entry.periodic) ? '0
                                                  : entry.count + 1'b1;
                            end
                            if (fire && !entry.periodic) begin
                                active_next[p_idx_reg] = 1'b0;
                            end
                            if (cap) begin
                                if (pend_valid_reg) begin
                                    m_valid_next   = 1'b1;
                                    m_kind_next    = KIND_FIRED;
                                    m_outcome_next = OUTCOME_OK;
                                    m_task_next    = pend_task_reg;
                                    m_event_next   = pend_event_reg;
                                    m_last_next    = 1'b0;
                                end
                                pend_valid_next = 1'b1;
                                pend_task_next  = entry.task_id;
                                pend_event_next = entry.event_num;
                                res_cnt_next    = res_cnt_reg + 1'b1;
                            end
                            if (at_end) begin
                                finish     = 1'b1;
                                state_next = (pend_valid_reg || cap) ? BK_FLUSH : BK_IDLE;
                            end
                        end
                    end else if (hit || at_end) begin
                        stall = !out_free;
                        if (!stall) begin
                            m_valid_next   = 1'b1;
                            m_kind_next    = KIND_REPLY;
                            m_outcome_next = hit ? OUTCOME_OK : OUTCOME_FAIL;
                            m_task_next    = '0;
                            m_event_next   = '0;
                            m_last_next    = 1'b1;
                            finish         = 1'b1;
                            state_next     = BK_IDLE;
                            if (hit) begin
                                case (cur_reg.op)
                                    OP_START_ONE, OP_START_PER: begin
                                        ram_we                 = 1'b1;
                                        ram_wdata.periodic     = (cur_reg.op == OP_START_PER);
                                        ram_wdata.task_id      = cur_reg.task_id;
                                        ram_wdata.event_num    = cur_reg.event_num;
                                        ram_wdata.count        = '0;
                                        ram_wdata.limit        = cur_reg.timeout;
                                        active_next[p_idx_reg] = 1'b1;
                                    end
                                    OP_RESTART: begin
                                        ram_we          = 1'b1;
                                        ram_wdata.count = '0;
                                    end
                                    OP_STOP: begin
                                        active_next[p_idx_reg] = 1'b0;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                        end
                    end
                end
                // The read for the next slot is issued while this one is evaluated.
                if (!stall) begin
                    ram_re = issuing;
                    if (finish) begin
                        p_valid_next = 1'b0;
                    end else begin
                        p_valid_next = issuing;
                        p_idx_next   = rd_idx_reg[IDX_W-1:0];
                        if (issuing) begin
                            rd_idx_next = rd_idx_reg + 1'b1;
                        end
                    end
                end
            end
            BK_FLUSH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_kind_next     = KIND_FIRED;
                    m_outcome_next  = OUTCOME_OK;
                    m_task_next     = pend_task_reg;
                    m_event_next    = pend_event_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            rd_idx_reg     <= '0;
            p_idx_reg      <= '0;
            p_valid_reg    <= 1'b0;
            active_reg     <= '0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            rd_idx_reg     <= rd_idx_next;
            p_idx_reg      <= p_idx_next;
            p_valid_reg    <= p_valid_next;
            active_reg     <= active_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        pend_task_reg  <= pend_task_next;
        pend_event_reg <= pend_event_next;
        m_kind_reg     <= m_kind_next;
        m_outcome_reg  <= m_outcome_next;
        m_task_reg     <= m_task_next;
        m_event_reg    <= m_event_next;
        m_last_reg     <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_outcome     = m_outcome_reg;
    assign m_fired_task  = m_task_reg;
    assign m_fired_event = m_event_reg;
    assign m_last        = m_last_reg;

endmodule
`default_nettype wire

/* src/multi_slot_event_timer_table.sv */
// Top level of the multi-slot event timer table.
//
// Commands enter on the s_ channel (valid/ready) and results leave on the m_ channel.
// Start, restart, stop and query each give one reply item; unknown command codes give a
// failure reply. A tick gives one item per firing slot in ascending slot order, at most
// MAX_RESULTS of them, with m_last on the final one, and no item at all if nothing fires.
// A two-entry command queue sits between the decoder and the table engine, so the input
// takes up to two items while the engine works or while a result waits in the output
// register. The engine sweeps the table one slot per cycle through the slot RAM read
// port while the output does not stall it. A tick hands out its final firing from the
// flush state after the sweep; start, restart, stop and query end at the first matching
// slot (a free one for a start) or fail at the last one; replies are registered. While the
// receiver holds m_ready low, the sweep stops at the next slot that must produce an item
// and resumes when the output register frees. Reset frees every slot at once through the
// per-slot active flags; the RAM contents need no clearing and the block accepts items
// right after reset.
`timescale 1ns / 1ps
`default_nettype none
module multi_slot_event_timer_table import met_pkg::*; #(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [CMD_W-1:0]   s_command,
    input  wire logic [TASK_W-1:0]  s_task_id,
    input  wire logic [EVENT_W-1:0] s_event_id,
    input  wire logic [COUNT_W-1:0] s_timeout,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_kind,
    output logic                    m_outcome,
    output logic [TASK_W-1:0]       m_fired_task,
    output logic [EVENT_W-1:0]      m_fired_event,
    output logic                    m_last
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    met_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_task_id  (s_task_id),
        .s_event_id (s_event_id),
        .s_timeout  (s_timeout),
        .cmd        (cmd),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready)
    );

    met_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_outcome     (m_outcome),
        .m_fired_task  (m_fired_task),
        .m_fired_event (m_fired_event),
        .m_last        (m_last)
    );

endmodule
`default_nettype wire

/* src/met_checker.sv */
// Port-level checker for the timer table and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module met_checker import met_pkg::*; (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic               m_kind,
    input wire logic               m_outcome,
    input wire logic [TASK_W-1:0]  m_fired_task,
    input wire logic [EVENT_W-1:0] m_fired_event,
    input wire logic               m_last
);

    // A result item that was not taken must still be offered in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item withdrawn before it was taken");

    // Every reply is the only item of its command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_REPLY) |-> m_last)
        else $error("reply item without last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_REPLY) |-> (m_fired_task == '0) && (m_fired_event == '0))
        else $error("reply item carries a task or event");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_FIRED) |-> (m_outcome == OUTCOME_OK))
        else $error("fired item with a failure outcome");

endmodule

bind multi_slot_event_timer_table met_checker u_met_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_kind        (m_kind),
    .m_outcome     (m_outcome),
    .m_fired_task  (m_fired_task),
    .m_fired_event (m_fired_event),
    .m_last        (m_last)
);
`default_nettype wire
